// ----- rtl/d2r_pkg.sv -----
// Shared types and constants for the bitmap byte to RGB888 converter.
// No dependencies; used by every module under rtl.
package d2r_pkg;

	// Saturation limit for the programmed image width
	localparam int MAX_WIDTH = 4096;
	// Default palette depth handed to the top level
	localparam int PALETTE_DEPTH = 256;
	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Input item kinds
	localparam logic OP_PAL_WRITE = 1'b0;
	localparam logic OP_PIXEL     = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;
	localparam logic [1:0] CFG_STRIDE = 2'd3;

	typedef enum logic [1:0] {
		MODE_BGR24 = 2'd0,
		MODE_PAL8  = 2'd1,
		MODE_PAL4  = 2'd2
	} pix_mode_t;

	typedef struct packed {
		pix_mode_t   mode;
		logic [12:0] width;
		logic [12:0] height;
		logic [13:0] stride;
	} cfg_t;

	// One classified request: a palette write or one or two pixels
	typedef struct packed {
		logic        is_write;
		logic        two;
		logic        direct;
		logic [23:0] rgb;
		logic [7:0]  idx0;
		logic [7:0]  idx1;
		logic        re0;
		logic        ie0;
		logic        re1;
		logic        ie1;
	} q_entry_t;

endpackage

// ----- rtl/d2r_front.sv -----
// Front part: accepts input requests, tracks row position and classifies each byte.
// Depends on d2r_pkg; pushes classified requests into d2r_queue.
module d2r_front (
	input  logic                clk,
	input  logic                arst_n,
	input  d2r_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [7:0]          source_byte,
	input  logic [7:0]          palette_index,
	input  logic [7:0]          palette_red,
	input  logic [7:0]          palette_green,
	input  logic [7:0]          palette_blue,
	input  logic                q_full,
	output logic                q_push,
	output d2r_pkg::q_entry_t   q_wdata
);

	localparam int          MW_CLIP = (d2r_pkg::MAX_WIDTH > 8191) ? 8191 : d2r_pkg::MAX_WIDTH;
	localparam logic [12:0] MW      = 13'(MW_CLIP);

	logic [12:0] pixel_col_q;
	logic [13:0] byte_col_q;
	logic [12:0] row_cnt_q;
	logic [1:0]  phase_q;
	logic [15:0] held_q;

	logic [12:0] eff_w;
	logic [13:0] pc1, pc2;
	logic        pc_lt, two_fit, img_last, row_done, accept, emits;
	logic [12:0] pc_next, rc_inc;
	logic [1:0]  phase_next;
	logic [15:0] held_next;
	logic [14:0] bc1;

	// Stall while the queue cannot take another request
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Row position compares
	always_comb begin
		eff_w    = (cfg.width > MW) ? MW : cfg.width;
		pc1      = {1'b0, pixel_col_q} + 14'd1;
		pc2      = {1'b0, pixel_col_q} + 14'd2;
		pc_lt    = pixel_col_q < eff_w;
		two_fit  = pc1 < {1'b0, eff_w};
		img_last = ({1'b0, row_cnt_q} + 14'd1) == {1'b0, cfg.height};
		bc1      = {1'b0, byte_col_q} + 15'd1;
		row_done = bc1 >= {1'b0, cfg.stride};
		rc_inc   = row_cnt_q + 13'd1;
	end

	// Classify the byte and build the queue request
	always_comb begin
		q_wdata          = '0;
		q_wdata.re0      = pc1 == {1'b0, eff_w};
		q_wdata.re1      = pc2 == {1'b0, eff_w};
		q_wdata.ie0      = q_wdata.re0 && img_last;
		q_wdata.ie1      = q_wdata.re1 && img_last;
		q_wdata.rgb      = {source_byte, held_q};
		q_wdata.idx0     = source_byte;
		q_wdata.idx1     = {4'd0, source_byte[3:0]};
		emits            = 1'b0;
		pc_next          = pixel_col_q;
		phase_next       = phase_q;
		held_next        = held_q;
		case (cfg.mode)
			d2r_pkg::MODE_BGR24: begin
				q_wdata.direct = 1'b1;
				if (pc_lt) begin
					case (phase_q)
						2'd0: begin
							held_next  = {held_q[15:8], source_byte};
							phase_next = 2'd1;
						end
						2'd1: begin
							held_next  = {source_byte, held_q[7:0]};
							phase_next = 2'd2;
						end
						default: begin
							phase_next = 2'd0;
							emits      = 1'b1;
							pc_next    = pc1[12:0];
						end
					endcase
				end
			end
			d2r_pkg::MODE_PAL8: begin
				emits   = pc_lt;
				pc_next = pc_lt ? pc1[12:0] : pixel_col_q;
			end
			d2r_pkg::MODE_PAL4: begin
				q_wdata.idx0 = {4'd0, source_byte[7:4]};
				q_wdata.two  = two_fit;
				emits        = pc_lt;
				if (pc_lt)
					pc_next = two_fit ? pc2[12:0] : pc1[12:0];
			end
			default: begin
				emits = 1'b0;
			end
		endcase
		if (opcode == d2r_pkg::OP_PAL_WRITE) begin
			q_wdata          = '0;
			q_wdata.is_write = 1'b1;
			q_wdata.idx0     = palette_index;
			q_wdata.rgb      = {palette_red, palette_green, palette_blue};
		end
	end

	assign q_push = accept && ((opcode == d2r_pkg::OP_PAL_WRITE) || emits);

	// Advance row state on every accepted image byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_col_q <= '0;
			byte_col_q  <= '0;
			row_cnt_q   <= '0;
			phase_q     <= '0;
			held_q      <= '0;
		end else if (accept && opcode == d2r_pkg::OP_PIXEL) begin
			held_q <= held_next;
			if (row_done) begin
				pixel_col_q <= '0;
				byte_col_q  <= '0;
				phase_q     <= '0;
				row_cnt_q   <= (rc_inc == cfg.height) ? 13'd0 : rc_inc;
			end else begin
				pixel_col_q <= pc_next;
				byte_col_q  <= bc1[13:0];
				phase_q     <= phase_next;
			end
		end
	end

endmodule

// ----- rtl/d2r_queue.sv -----
// Short request queue between the front and back parts.
// Depends on d2r_pkg for the request type and depth.
module d2r_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  d2r_pkg::q_entry_t wdata,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output d2r_pkg::q_entry_t rdata
);

	localparam int PW = $clog2(d2r_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(d2r_pkg::QUEUE_DEPTH + 1);

	d2r_pkg::q_entry_t slot_q [d2r_pkg::QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full  = count_q == CW'(d2r_pkg::QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign rdata = slot_q[rd_ptr_q];

	// Store requests
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wdata;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// ----- rtl/d2r_back.sv -----
// Back part: palette memory, read stage and output register; one pixel issued per cycle
// unless stalled. Depends on d2r_pkg; drains requests from d2r_queue.
module d2r_back #(
	parameter int PALETTE_DEPTH = d2r_pkg::PALETTE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  d2r_pkg::q_entry_t q_rdata,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic              row_end,
	output logic              image_end,
	output logic              last_of_item
);

	localparam int          AW    = $clog2(PALETTE_DEPTH);
	localparam logic [8:0]  DEPTH = 9'(PALETTE_DEPTH);

	logic [23:0] palette_mem [PALETTE_DEPTH];

	logic          sub_q;
	logic          s1_valid_s1, direct_s1, oor_s1, re_s1, ie_s1, last_s1;
	logic [23:0]   rgb_s1, rd_s1;
	logic          out_valid_q;
	logic [23:0]   out_rgb_q;
	logic          out_re_q, out_ie_q, out_last_q;

	logic          is_w, issue, issue_pix, s1_ready, s2_ready, w_oor, sel_oor;
	logic [7:0]    sel_idx;
	logic [AW-1:0] rd_addr;

	assign s2_ready  = !out_valid_q || !out_stall;
	assign s1_ready  = !s1_valid_s1 || s2_ready;
	assign is_w      = q_rdata.is_write;
	assign issue     = q_valid && (is_w || s1_ready);
	assign issue_pix = issue && !is_w;
	assign q_pop     = issue && (is_w || !q_rdata.two || sub_q);

	// Select the pixel of the head request
	assign sel_idx = sub_q ? q_rdata.idx1 : q_rdata.idx0;
	assign sel_oor = {1'b0, sel_idx} >= DEPTH;
	assign w_oor   = {1'b0, q_rdata.idx0} >= DEPTH;
	assign rd_addr = sel_oor ? '0 : sel_idx[AW-1:0];

	// Palette write and registered read
	always_ff @(posedge clk) begin
		if (issue && is_w && !w_oor)
			palette_mem[q_rdata.idx0[AW-1:0]] <= q_rdata.rgb;
		if (issue_pix)
			rd_s1 <= palette_mem[rd_addr];
	end

	// Hold pixel metadata beside the read data
	always_ff @(posedge clk) begin
		if (issue_pix) begin
			direct_s1 <= q_rdata.direct;
			rgb_s1    <= q_rdata.rgb;
			oor_s1    <= sel_oor;
			re_s1     <= sub_q ? q_rdata.re1 : q_rdata.re0;
			ie_s1     <= sub_q ? q_rdata.ie1 : q_rdata.ie0;
			last_s1   <= !q_rdata.two || sub_q;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (s2_ready && s1_valid_s1) begin
			out_rgb_q  <= direct_s1 ? rgb_s1 : (oor_s1 ? 24'd0 : rd_s1);
			out_re_q   <= re_s1;
			out_ie_q   <= ie_s1;
			out_last_q <= last_s1;
		end
	end

	// Advance valid flags and the pixel selector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= 1'b0;
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue_pix && q_rdata.two)
				sub_q <= !sub_q;
			if (s1_ready)
				s1_valid_s1 <= issue_pix;
			if (s2_ready)
				out_valid_q <= s1_valid_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = out_rgb_q[23:16];
	assign green        = out_rgb_q[15:8];
	assign blue         = out_rgb_q[7:0];
	assign row_end      = out_re_q;
	assign image_end    = out_ie_q;
	assign last_of_item = out_last_q;

endmodule

// ----- rtl/dib_to_rgb_pixel_converter.sv -----
// Bitmap byte stream to RGB888 converter: configuration registers, front, queue, back.
// An accepted byte's request passes the queue, the read stage and the output register.
// Throughput: one byte per cycle in 24-bit and 8-bit modes while nothing stalls; in 4-bit
// mode the rate is set by one pixel issued per cycle through the single palette read port.
// Reset clears row counters, queue and valid flags; palette contents are undefined
// until written. Depends on d2r_pkg, d2r_front, d2r_queue, d2r_back.
module dib_to_rgb_pixel_converter #(
	parameter int PALETTE_DEPTH = d2r_pkg::PALETTE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  source_byte,
	input  logic [7:0]  palette_index,
	input  logic [7:0]  palette_red,
	input  logic [7:0]  palette_green,
	input  logic [7:0]  palette_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        row_end,
	output logic        image_end,
	output logic        last_of_item
);

	d2r_pkg::cfg_t     cfg_q;
	d2r_pkg::q_entry_t q_wdata, q_rdata;
	logic              q_push, q_full, q_pop, q_valid;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= d2r_pkg::MODE_BGR24;
			cfg_q.width  <= 13'd1;
			cfg_q.height <= 13'd1;
			cfg_q.stride <= 14'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				d2r_pkg::CFG_MODE:   cfg_q.mode   <= d2r_pkg::pix_mode_t'(cfg_data[1:0]);
				d2r_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data[12:0];
				d2r_pkg::CFG_HEIGHT: cfg_q.height <= cfg_data[12:0];
				d2r_pkg::CFG_STRIDE: cfg_q.stride <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	d2r_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.source_byte   (source_byte),
		.palette_index (palette_index),
		.palette_red   (palette_red),
		.palette_green (palette_green),
		.palette_blue  (palette_blue),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_wdata       (q_wdata)
	);

	d2r_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	d2r_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_rdata      (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.row_end      (row_end),
		.image_end    (image_end),
		.last_of_item (last_of_item)
	);

	// A full queue always has a request at its head
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> q_valid)
		else $error("queue full but empty");

	// One pop per cycle cannot drain a full queue
	a_full_drain: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |=> q_valid)
		else $error("queue drained from full in one cycle");

	// Image end only on the last pixel of a row
	a_image_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image end without row end");

endmodule
